FILE: rtl/core/mtlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtlc_pkg
// shared types and constants of the meter information line checker
// ----------------------------------------------------------------------------
package mtlc_pkg;

    // label characters kept for the dated label check
    localparam int LABEL_PREFIX_CHARS = 4;
    localparam int LABEL_KEEP = (LABEL_PREFIX_CHARS < 7) ? LABEL_PREFIX_CHARS : 7;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] SUM_BASE = 8'h20;
    localparam logic [5:0] SUM_MASK = 6'h3F;

    localparam logic MODE_STANDARD = 1'b0;
    localparam logic MODE_HISTORIC = 1'b1;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_CHECKSUM = 3'd1;
    localparam logic [2:0] ERR_NO_DATE  = 3'd2;
    localparam logic [2:0] ERR_OUTSIDE  = 3'd3;
    localparam logic [2:0] ERR_EMPTY    = 3'd4;

    localparam logic [2:0] FIELD_MAX = 3'd7;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        K_LF,
        K_IGNORE,
        K_CR,
        K_SEP,
        K_DATA
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [2:0] error_kind;
        logic       line_ok;
        logic       line_done;
        logic       char_valid;
        logic [7:0] char_value;
        logic [2:0] field_index;
    } t_result;

    function automatic logic [7:0] fold_sum(input logic [7:0] s);
        return {2'b00, s[5:0] & SUM_MASK} + SUM_BASE;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mtlc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtlc_front
// accepts received bytes and tags each with its byte class
// ----------------------------------------------------------------------------
module mtlc_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_mode,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [7:0]        i_byte,
    output logic              o_valid,
    input  wire               i_ready,
    output mtlc_pkg::t_item   o_item
);
    import mtlc_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.rx_byte = i_byte;
        priority if (i_byte == CH_LF) begin
            n_item.kind = K_LF;
        end else if (i_byte >= CH_STX && i_byte <= CH_EOT) begin
            n_item.kind = K_IGNORE;
        end else if (i_byte == CH_CR) begin
            n_item.kind = K_CR;
        end else if ((i_mode == MODE_STANDARD && i_byte == CH_TAB) ||
                     (i_mode == MODE_HISTORIC && i_byte == CH_SPACE)) begin
            n_item.kind = K_SEP;
        end else begin
            n_item.kind = K_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/mtlc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtlc_queue
// short queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module mtlc_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  mtlc_pkg::t_item   i_item,
    output logic              o_valid,
    input  wire               i_ready,
    output mtlc_pkg::t_item   o_item
);
    import mtlc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (pop) begin
                r_rptr <= ptr_next(r_rptr);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/mtlc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtlc_back
// line state, checksum and verdict for each classified byte
// ----------------------------------------------------------------------------
module mtlc_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_mode,
    input  wire               i_valid,
    output logic              o_ready,
    input  mtlc_pkg::t_item   i_item,
    output logic              o_valid,
    input  wire               i_ready,
    output mtlc_pkg::t_result o_result
);
    import mtlc_pkg::*;

    logic       r_open;
    logic [2:0] r_field;
    logic [2:0] r_lcount;
    logic [7:0] r_sum;
    logic [7:0] r_sum_sep;
    logic [7:0] r_check;
    logic [7:0] r_label [LABEL_KEEP];

    logic       n_open;
    logic [2:0] n_field;
    logic [2:0] n_lcount;
    logic [7:0] n_sum;
    logic [7:0] n_sum_sep;
    logic [7:0] n_check;
    logic       label_wr;
    logic       label_clr;

    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;

    logic       take;
    logic       dated;
    logic [2:0] field_inc;
    logic [7:0] c;

    assign o_ready  = !r_out_valid || i_ready;
    assign take     = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign c        = i_item.rx_byte;
    assign field_inc = (r_field == FIELD_MAX) ? r_field : r_field + 3'd1;

    // labels that must carry a timestamp
    assign dated = (r_label[0] == "S" && r_label[1] == "M" &&
                    r_label[2] == "A" && r_label[3] == "X") ||
                   (r_label[0] == "C" && r_label[1] == "C" && r_label[2] == "A") ||
                   (r_label[0] == "U" && r_label[1] == "M" &&
                    r_label[2] == "O" && r_label[3] == "Y") ||
                   (r_label[0] == "D" && r_label[1] == "M" && r_label[2] == "P") ||
                   (r_label[0] == "F" && r_label[1] == "P" && r_label[2] == "M");

    always_comb begin
        n_open    = r_open;
        n_field   = r_field;
        n_lcount  = r_lcount;
        n_sum     = r_sum;
        n_sum_sep = r_sum_sep;
        n_check   = r_check;
        label_wr  = 1'b0;
        label_clr = 1'b0;
        n_out             = '0;
        n_out.field_index = r_field;

        unique case (i_item.kind)
            K_LF: begin
                n_open    = 1'b1;
                n_field   = '0;
                n_lcount  = '0;
                n_sum     = '0;
                n_sum_sep = '0;
                n_check   = '0;
                label_clr = 1'b1;
                n_out.field_index = '0;
            end
            K_IGNORE: begin
            end
            K_CR: begin
                if (!r_open) begin
                    n_out.error_kind = ERR_OUTSIDE;
                end else begin
                    n_open = 1'b0;
                    n_out.line_done = 1'b1;
                    if (r_field == '0) begin
                        n_out.error_kind = ERR_EMPTY;
                    end else if (i_mode == MODE_STANDARD) begin
                        if (r_field == 3'd2) begin
                            if (dated) begin
                                n_out.error_kind = ERR_NO_DATE;
                            end else if (fold_sum(r_sum_sep) == r_check) begin
                                n_out.line_ok = 1'b1;
                            end else begin
                                n_out.error_kind = ERR_CHECKSUM;
                            end
                        end else if (r_field == 3'd3) begin
                            if (fold_sum(r_sum) == r_check) begin
                                n_out.line_ok = 1'b1;
                            end else begin
                                n_out.error_kind = ERR_CHECKSUM;
                            end
                        end
                    end else if (r_field >= 3'd2) begin
                        if (fold_sum(r_sum) == r_check) begin
                            n_out.line_ok = 1'b1;
                        end else begin
                            n_out.error_kind = ERR_CHECKSUM;
                        end
                    end
                end
            end
            K_SEP: begin
                if (i_mode == MODE_STANDARD) begin
                    if (!r_open) begin
                        n_out.error_kind = ERR_OUTSIDE;
                    end else begin
                        n_field   = field_inc;
                        n_sum     = r_sum + CH_TAB;
                        n_sum_sep = r_sum + CH_TAB;
                        n_out.field_index = field_inc;
                    end
                end else if (r_open) begin
                    // historic space: a separator, or the checksum itself
                    n_field = field_inc;
                    n_out.field_index = field_inc;
                    if (field_inc < 3'd2) begin
                        n_sum = r_sum + CH_SPACE;
                    end else begin
                        n_check = CH_SPACE;
                        n_out.char_valid = 1'b1;
                        n_out.char_value = c;
                    end
                end
            end
            K_DATA: begin
                if (!r_open) begin
                    n_out.error_kind = ERR_OUTSIDE;
                end else begin
                    n_out.char_valid = 1'b1;
                    n_out.char_value = c;
                    if (r_field == '0) begin
                        label_wr = 1'b1;
                        if (r_lcount != FIELD_MAX) begin
                            n_lcount = r_lcount + 3'd1;
                        end
                    end
                    if (i_mode == MODE_STANDARD) begin
                        if (r_field < 3'd2) begin
                            n_sum     = r_sum + c;
                            n_sum_sep = r_sum + c;
                        end else if (r_field == 3'd2) begin
                            n_sum   = r_sum + c;
                            n_check = c;
                        end else begin
                            n_check = c;
                        end
                    end else begin
                        if (r_field < 3'd2) begin
                            n_sum = r_sum + c;
                        end else begin
                            n_check = c;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_field     <= '0;
            r_lcount    <= '0;
            r_sum       <= '0;
            r_sum_sep   <= '0;
            r_check     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_open    <= n_open;
                r_field   <= n_field;
                r_lcount  <= n_lcount;
                r_sum     <= n_sum;
                r_sum_sep <= n_sum_sep;
                r_check   <= n_check;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    // label prefix, one byte per kept character
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LABEL_KEEP; k++) begin
            if (!i_rst_n || (take && label_clr)) begin
                r_label[k] <= '0;
            end else if (take && label_wr && r_lcount == 3'(k)) begin
                r_label[k] <= c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/meter_teleinfo_line_checker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// meter_teleinfo_line_checker_top
// per-byte field tagging and checksum verdict for meter information lines
// ----------------------------------------------------------------------------
// Feed received bytes on the slave stream; every byte yields exactly one
// result transaction on the master stream, in order. The block sustains one
// byte per clock while the sink does not stall: the front stage tags each
// byte, a two-entry queue holds tagged bytes, and the back stage updates the
// line state and registers the result, so a byte's result passes through the
// front register, the queue and the back result register. Throughput is set
// by the line state update in the back stage. line_mode selects standard
// (tab) or historic (space) lines and should only be written while no byte
// is in flight. Field storage, including any timestamp copy, is up to the
// logic downstream of char_value.
module meter_teleinfo_line_checker_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration: line_mode
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_data,
    // received bytes
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // per-byte results
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] char_value
    output logic [8:0]  o_m_axis_tuser    // [2:0] field_index, [3] char_valid,
                                          // [4] line_done, [5] line_ok,
                                          // [8:6] error_kind
);
    import mtlc_pkg::*;

    logic    r_mode;

    // front to queue
    logic    fq_valid;
    logic    fq_ready;
    t_item   fq_item;

    // queue to back
    logic    qb_valid;
    logic    qb_ready;
    t_item   qb_item;

    t_result result;

    // configuration always taken at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_STANDARD;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    mtlc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .o_valid (fq_valid),
        .i_ready (fq_ready),
        .o_item  (fq_item)
    );

    mtlc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_item  (fq_item),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_item  (qb_item)
    );

    mtlc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_valid  (qb_valid),
        .o_ready  (qb_ready),
        .i_item   (qb_item),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    // result packing, lowest field first
    assign o_m_axis_tdata = result.char_value;
    assign o_m_axis_tuser = {result.error_kind, result.line_ok, result.line_done,
                             result.char_valid, result.field_index};

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the meter information line checker
// ----------------------------------------------------------------------------
// Streams standard (tab) and historic (space) lines through the byte port:
// well-formed lines with random labels, dates and values, lines with a bad
// checksum, a missing carriage return, a stray control byte, an early line
// feed or a spare separator, odd field counts and raw noise. A line-state
// tracker predicts every per-byte result and compares it field by field.
// The sender works in bursts with random gaps, the sink stalls on its own
// pattern, and one phase holds the sink off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
    import mtlc_pkg::*;

    typedef logic [7:0] t_chars [$];

    // ways of spoiling an otherwise well-formed line
    typedef enum int {
        FLAW_NONE,
        FLAW_CHECKSUM,
        FLAW_CONTROL,
        FLAW_NO_CR,
        FLAW_RESTART,
        FLAW_EXTRA_SEP
    } t_flaw;

    localparam int IDLE_LIMIT      = 2000;  // cycles with no transaction at all
    localparam int HOLD_OFF_CYCLES = 80;    // long sink stall in the pressure phase
    localparam int PHASE_BYTES     = 105;

    // ------------------------------------------------------------------------
    // line-state tracker: predicts the result of every accepted byte
    // ------------------------------------------------------------------------
    class teleinfo_line_tracker;
        logic       line_mode   = MODE_STANDARD;
        logic       line_open   = 1'b0;
        logic [2:0] field_pos   = 3'd0;
        logic [2:0] label_count = 3'd0;
        logic [7:0] total_sum   = 8'h00;
        logic [7:0] sep_sum     = 8'h00;
        logic [7:0] check_char  = 8'h00;
        logic [7:0] label_chars [8] = '{default: 8'h00};
        t_result    awaited_results [$];
        int errors        = 0;
        int bytes_seen    = 0;
        int historic_seen = 0;
        int results_seen  = 0;
        int lines_closed  = 0;
        int lines_passed  = 0;

        function logic [7:0] folded(logic [7:0] s);
            return {2'b00, s[5:0]} + SUM_BASE;
        endfunction

        function void set_mode(logic m);
            line_mode = m;
        endfunction

        function bit label_is(string s);
            for (int k = 0; k < s.len(); k++) begin
                if (((k < LABEL_KEEP) ? label_chars[k] : 8'h00) != s[k])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // labels that must carry a timestamp in standard lines
        function bit dated_label();
            return label_is("SMAX") || label_is("CCA") || label_is("UMOY") ||
                   label_is("DMP") || label_is("FPM");
        endfunction

        function void judge(logic [7:0] s, inout t_result r);
            r.line_ok    = (folded(s) == check_char);
            r.error_kind = r.line_ok ? ERR_NONE : ERR_CHECKSUM;
        endfunction

        function void take_rx_byte(logic [7:0] c);
            t_result r;
            r             = '0;
            r.field_index = field_pos;
            bytes_seen++;
            if (line_mode == MODE_HISTORIC)
                historic_seen++;

            if (c == CH_LF) begin
                line_open   = 1'b1;
                field_pos   = 3'd0;
                label_count = 3'd0;
                total_sum   = 8'h00;
                sep_sum     = 8'h00;
                check_char  = 8'h00;
                foreach (label_chars[k])
                    label_chars[k] = 8'h00;
                r.field_index = 3'd0;
            end else if (c >= CH_STX && c <= CH_EOT) begin
                // control bytes leave the line state alone
            end else if (c == CH_CR) begin
                if (!line_open) begin
                    r.error_kind = ERR_OUTSIDE;
                end else begin
                    line_open   = 1'b0;
                    r.line_done = 1'b1;
                    if (field_pos == 3'd0) begin
                        r.error_kind = ERR_EMPTY;
                    end else if (line_mode == MODE_STANDARD) begin
                        if (field_pos == 3'd2) begin
                            if (dated_label())
                                r.error_kind = ERR_NO_DATE;
                            else
                                judge(sep_sum, r);
                        end else if (field_pos == 3'd3) begin
                            judge(total_sum, r);
                        end
                    end else if (field_pos >= 3'd2) begin
                        judge(total_sum, r);
                    end
                end
            end else if (line_mode == MODE_STANDARD && c == CH_TAB) begin
                if (!line_open) begin
                    r.error_kind = ERR_OUTSIDE;
                end else begin
                    if (field_pos != FIELD_MAX)
                        field_pos++;
                    total_sum     = total_sum + CH_TAB;
                    sep_sum       = total_sum;
                    r.field_index = field_pos;
                end
            end else if (line_mode == MODE_HISTORIC && c == CH_SPACE) begin
                // a space outside a historic line is dropped silently
                if (line_open) begin
                    if (field_pos != FIELD_MAX)
                        field_pos++;
                    r.field_index = field_pos;
                    if (field_pos < 3'd2) begin
                        total_sum = total_sum + CH_SPACE;
                    end else begin
                        check_char   = CH_SPACE;
                        r.char_valid = 1'b1;
                    end
                end
            end else if (!line_open) begin
                r.error_kind = ERR_OUTSIDE;
            end else begin
                r.char_valid = 1'b1;
                if (field_pos == 3'd0) begin
                    if (label_count < LABEL_KEEP)
                        label_chars[label_count] = c;
                    if (label_count != 3'd7)
                        label_count++;
                end
                if (field_pos < 3'd2) begin
                    total_sum = total_sum + c;
                    if (line_mode == MODE_STANDARD)
                        sep_sum = total_sum;
                end else if (field_pos == 3'd2 && line_mode == MODE_STANDARD) begin
                    total_sum  = total_sum + c;
                    check_char = c;
                end else begin
                    check_char = c;
                end
            end

            if (r.char_valid)
                r.char_value = c;
            if (r.line_done)
                lines_closed++;
            if (r.line_ok)
                lines_passed++;
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [7:0] data, logic [8:0] user);
            t_result e;
            results_seen++;
            if (awaited_results.size() == 0) begin
                $error("result with no byte awaiting it: tdata 0x%02h tuser 0x%03h",
                       data, user);
                errors++;
                return;
            end
            e = awaited_results.pop_front();
            compare_field("field_index", e.field_index, user[2:0]);
            compare_field("char_value",  e.char_value,  data);
            compare_field("char_valid",  e.char_valid,  user[3]);
            compare_field("line_done",   e.line_done,   user[4]);
            compare_field("line_ok",     e.line_ok,     user[5]);
            compare_field("error_kind",  e.error_kind,  user[8:6]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_valid     = 1'b0;
    logic       i_cfg_data      = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata  = 8'h00;
    logic       i_m_axis_tready = 1'b0;
    logic       o_cfg_ready;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic [8:0] o_m_axis_tuser;

    teleinfo_line_tracker tracker = new();

    t_chars tx_q;                 // bytes still to be offered
    bit     sender_gaps   = 1'b1;
    bit     hold_off_req  = 1'b0;
    int     burst_left    = 0;
    int     idle_cycles   = 0;

    always #5 i_clk = ~i_clk;

    meter_teleinfo_line_checker_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] rx_byte
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [7:0] char_value
        .o_m_axis_tuser  (o_m_axis_tuser)    // [2:0] field_index, [3] char_valid,
                                             // [4] line_done, [5] line_ok,
                                             // [8:6] error_kind
    );

    // ------------------------------------------------------------------------
    // monitor: every transaction is seen here at the clock edge, before any
    // of this step's nonblocking updates land
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                tracker.check_result(o_m_axis_tdata, o_m_axis_tuser);
            if (i_cfg_valid && o_cfg_ready)
                tracker.set_mode(i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready)
                tracker.take_rx_byte(i_s_axis_tdata);
        end
    end

    // watchdog: too long without any transaction means the block is stuck
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result sink: stretches of full speed, random and alternating readiness
    // and heavy stalling, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : sink
        int seg_kind;
        int seg_len;
        forever begin
            if (hold_off_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                seg_kind = $urandom_range(0, 3);
                seg_len  = $urandom_range(4, 40);
                for (int n = 0; n < seg_len && !hold_off_req; n++) begin
                    case (seg_kind)
                        0:       i_m_axis_tready <= 1'b1;
                        1:       i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                        2:       i_m_axis_tready <= n[0];
                        default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------------
    // offer every queued byte, in bursts with gaps between them
    task automatic send_queued();
        logic [7:0] c;
        int         gap;
        while (tx_q.size() != 0) begin
            c = tx_q.pop_front();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = (!sender_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    i_s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= c;
            do @(posedge i_clk); while (!o_s_axis_tready);
        end
        i_s_axis_tvalid <= 1'b0;
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain();
        @(posedge i_clk);
        while (tracker.awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // line construction
    // ------------------------------------------------------------------------
    function automatic t_chars to_chars(string s);
        t_chars q;
        for (int k = 0; k < s.len(); k++)
            q.push_back(s[k]);
        return q;
    endfunction

    // printable characters, never a separator or a control byte
    function automatic t_chars rand_text(int n);
        t_chars q;
        repeat (n) q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        return q;
    endfunction

    // dated labels, near misses and ordinary labels, sometimes with a tail
    function automatic t_chars pick_label();
        string  names [8] = '{"SMAX", "CCA", "UMOY", "DMP", "FPM", "SMA", "DATE", "EASF01"};
        t_chars q;
        if ($urandom_range(0, 2) == 0)
            return rand_text($urandom_range(1, 9));
        q = to_chars(names[$urandom_range(0, 7)]);
        if ($urandom_range(0, 1) == 1)
            q = {q, rand_text($urandom_range(1, 3))};
        return q;
    endfunction

    // queue one line with a correct checksum, then spoil it as asked
    task automatic push_line(logic hist, t_chars label, t_chars date, t_chars value,
                             t_flaw flaw);
        t_chars     ln;
        logic [7:0] sep;
        logic [7:0] total;
        logic [7:0] chk;
        int         at;
        sep = hist ? CH_SPACE : CH_TAB;
        ln  = label;
        ln.push_back(sep);
        if (!hist && date.size() != 0) begin
            ln = {ln, date};
            ln.push_back(sep);
        end
        ln = {ln, value};
        // the standard checksum covers the last tab, the historic one not
        if (!hist)
            ln.push_back(sep);
        total = 8'h00;
        foreach (ln[k])
            total += ln[k];
        chk = tracker.folded((flaw == FLAW_CHECKSUM) ? total + 8'd1 : total);
        if (hist)
            ln.push_back(sep);
        ln.push_back(chk);
        ln.push_back(CH_CR);
        ln.push_front(CH_LF);
        at = $urandom_range(1, ln.size() - 1);
        case (flaw)
            FLAW_CONTROL:   ln.insert(at, 8'($urandom_range(CH_STX, CH_EOT)));
            FLAW_NO_CR:     void'(ln.pop_back());
            FLAW_RESTART:   ln.insert(at, CH_LF);
            FLAW_EXTRA_SEP: ln.insert(at, sep);
            default:        ;
        endcase
        tx_q = {tx_q, ln};
    endtask

    // mostly well-formed lines, the rest broken lines, odd counts and noise
    task automatic push_random(logic hist);
        t_chars date;
        int     pick;
        pick = $urandom_range(0, 99);
        if (!hist && $urandom_range(0, 1) == 1)
            date = rand_text($urandom_range(1, 13));
        if (pick < 70) begin
            push_line(hist, pick_label(), date, rand_text($urandom_range(1, 12)), FLAW_NONE);
        end else if (pick < 85) begin
            push_line(hist, pick_label(), date, rand_text($urandom_range(1, 12)),
                      t_flaw'($urandom_range(FLAW_CHECKSUM, FLAW_EXTRA_SEP)));
        end else if (pick < 93) begin
            repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            // any number of fields, up to past saturation
            tx_q.push_back(CH_LF);
            tx_q = {tx_q, rand_text($urandom_range(0, 3))};
            repeat ($urandom_range(0, 9)) begin
                tx_q.push_back(hist ? CH_SPACE : CH_TAB);
                tx_q = {tx_q, rand_text($urandom_range(0, 2))};
            end
            tx_q.push_back(CH_CR);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_chars no_date;
        logic   phase_mode;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // standard: extreme bytes, a stray carriage return and a stray tab outside a
        // line, an ignored control byte, an empty line, a dated label with no date
        write_mode(MODE_STANDARD);
        tx_q = {8'h00, 8'hFF, CH_CR, CH_TAB, CH_STX, CH_LF, CH_CR};
        push_line(MODE_STANDARD, to_chars("DMP"), no_date, to_chars("1"), FLAW_NONE);
        send_queued();
        drain();

        // historic: a space outside a line, and a line whose checksum is a space
        write_mode(MODE_HISTORIC);
        tx_q.push_back(CH_SPACE);
        push_line(MODE_HISTORIC, to_chars("A"), no_date, to_chars("_"), FLAW_NONE);
        send_queued();
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            phase_mode = phase[0];
            write_mode(phase_mode);
            if (phase == 5) begin
                // framing switched while a line is open
                tx_q.push_back(CH_LF);
                tx_q = {tx_q, to_chars("ADCO")};
                tx_q.push_back(phase_mode ? CH_SPACE : CH_TAB);
                send_queued();
                drain();
                phase_mode = ~phase_mode;
                write_mode(phase_mode);
            end
            if (phase == 3) begin
                // back-to-back bytes against a long sink hold-off
                sender_gaps  = 1'b0;
                hold_off_req = 1'b1;
            end
            while (tx_q.size() < PHASE_BYTES)
                push_random(phase_mode);
            send_queued();
            drain();
            sender_gaps = 1'b1;
        end

        repeat (10) @(posedge i_clk);
        $display("summary: %0d bytes checked (%0d in historic framing), %0d results",
                 tracker.bytes_seen, tracker.historic_seen, tracker.results_seen);
        $display("summary: %0d lines closed, %0d with a good checksum, one long sink hold-off",
                 tracker.lines_closed, tracker.lines_passed);
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
